/* sv/polygon_winding_containment_unit_assert.svh */
// Assertion macros for the polygon winding containment unit.
`ifndef POLYGON_WINDING_CONTAINMENT_UNIT_ASSERT_SVH
`define POLYGON_WINDING_CONTAINMENT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PWC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PWC_ASSERT_IMP(label, ante, cons)
`define PWC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/pwc_pkg.sv */
// Shared types and codes for the polygon winding containment unit.
package pwc_pkg;
  localparam logic [1:0] OP_APPEND   = 2'd0;
  localparam logic [1:0] OP_CLEAR    = 2'd1;
  localparam logic [1:0] OP_CONTAINS = 2'd2;
  localparam logic [1:0] OP_INTERIOR = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_FEW  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CAND_RD, S_CAND_A, S_CAND_B, S_CAND_C, S_EDGE_FIRST, S_EDGE_RD, S_EDGE_A,
    S_EDGE_B, S_EDGE_C, S_EDGE_D, S_EDGE_E, S_DONE
  } state_t;
endpackage

/* sv/pwc_ram.sv */
// Generic single-port RAM with registered read.
module pwc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* sv/polygon_winding_containment_unit.sv */
// Top level of the polygon winding containment unit.
// Keeps one polygon's vertices in a RAM and answers containment and interior-point queries.
// A command word is taken when start is high and busy is low; its single result sits on the
// result ports for the one cycle that done is high. The receiver cannot stall, so no result
// is ever held. Append and clear go through S_DONE and then the done register. The vertex
// RAM has one port, so in a contains query each edge runs through the read, capture,
// difference, multiply, compare and count states, S_EDGE_RD to S_EDGE_E, with no overlap.
// An interior search on N stored vertices runs up to N candidate walks (reads and setup in
// S_CAND_RD to S_CAND_C, plus the walk) and one more for the box center. The next command
// can be taken in the cycle that done is high.
module polygon_winding_containment_unit
  import pwc_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic signed [COORD_BITS-1:0] x_coord,
  input  logic signed [COORD_BITS-1:0] y_coord,
  output logic                        done,
  output logic                        inside_res,
  output logic signed [COORD_BITS+2:0] point_x_six,
  output logic signed [COORD_BITS+2:0] point_y_six,
  output logic [1:0]                  status
);
  `include "polygon_winding_containment_unit_assert.svh"

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int PW = COORD_BITS + 3;   // sixths
  localparam int DW = COORD_BITS + 1;   // edge delta
  localparam int OW = PW + 1;           // point offset
  localparam int MW = DW + OW;          // product
  localparam logic signed [COORD_BITS-1:0] TOP = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] BOT = {1'b1, {(COORD_BITS-1){1'b0}}};

  state_t state, state_next;
  logic [CW-1:0] count;
  logic signed [COORD_BITS-1:0] bminx, bminy, bmaxx, bmaxy;
  logic [1:0] cur_op;
  logic [AW-1:0] addr;
  logic we;
  logic [2*COORD_BITS-1:0] rdata;
  logic signed [COORD_BITS-1:0] rx, ry;
  // candidate, edge walk
  logic [CW-1:0] cand;    // candidate index, count = box centre
  logic [1:0] cnum;       // vertex in triple
  logic signed [PW-1:0] px, py, accx, accy;
  logic [CW-1:0] ei;      // edge index
  logic signed [COORD_BITS-1:0] sx, sy; // edge start vertex
  logic signed [COORD_BITS-1:0] ex, ey;
  logic signed [DW-1:0] dx, dy;
  logic signed [OW-1:0] ox, oy;
  logic signed [MW-1:0] m1, m2;
  logic up, dn;
  logic signed [CW:0] wind;
  logic signed [CW:0] wind_next;

  assign rx = $signed(rdata[2*COORD_BITS-1:COORD_BITS]);
  assign ry = $signed(rdata[COORD_BITS-1:0]);
  assign wind_next = wind + $signed({{CW{1'b0}}, up}) - $signed({{CW{1'b0}}, dn});

  pwc_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_VERTICES)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata({x_coord, y_coord}), .rdata(rdata)
  );

  logic accept;
  assign accept = start && !busy;
  assign busy = (state != S_IDLE);

  function automatic logic [CW-1:0] wrap(input logic [CW-1:0] v, input logic [CW-1:0] n);
    return (v >= n) ? v - n : v;
  endfunction

  logic [CW-1:0] ei_next;
  assign ei_next = ei + CW'(1);
  logic last_edge;
  assign last_edge = (ei_next == count);
  logic [CW-1:0] cand_idx;
  assign cand_idx = wrap(cand + CW'(cnum), count);

  always_comb begin
    we = 1'b0;
    addr = '0;
    if (state == S_IDLE) begin
      we = accept && (op == OP_APPEND) && (count != CW'(MAX_VERTICES));
      addr = count[AW-1:0];
    end else if (state == S_CAND_RD || state == S_CAND_A || state == S_CAND_B) begin
      addr = cand_idx[AW-1:0];
    end else if (state == S_EDGE_RD) begin
      addr = last_edge ? '0 : ei_next[AW-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) begin
        if (op == OP_CONTAINS && count >= CW'(3)) state_next = S_EDGE_FIRST;
        else if (op == OP_INTERIOR && count >= CW'(3)) state_next = S_CAND_RD;
        else state_next = S_DONE;
      end
      S_CAND_RD: state_next = S_CAND_A;
      S_CAND_A: state_next = S_CAND_B;
      S_CAND_B: state_next = S_CAND_C;
      S_CAND_C: state_next = S_EDGE_FIRST;
      S_EDGE_FIRST: state_next = S_EDGE_RD;
      S_EDGE_RD: state_next = S_EDGE_A;
      S_EDGE_A: state_next = S_EDGE_B;
      S_EDGE_B: state_next = S_EDGE_C;
      S_EDGE_C: state_next = S_EDGE_D;
      S_EDGE_D: state_next = S_EDGE_E;
      S_EDGE_E: begin
        if (!last_edge) state_next = S_EDGE_RD;
        else if (cur_op == OP_CONTAINS) state_next = S_DONE;
        else if (wind_next != '0) state_next = S_DONE;
        else if (cand == count) state_next = S_DONE;
        else if (cand + CW'(1) == count) state_next = S_EDGE_FIRST;
        else state_next = S_CAND_RD;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      bminx <= TOP; bminy <= TOP; bmaxx <= BOT; bmaxy <= BOT;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == S_DONE);
      if (accept && op == OP_APPEND && count != CW'(MAX_VERTICES)) begin
        count <= count + CW'(1);
        if (x_coord < bminx) bminx <= x_coord;
        if (y_coord < bminy) bminy <= y_coord;
        if (x_coord > bmaxx) bmaxx <= x_coord;
        if (y_coord > bmaxy) bmaxy <= y_coord;
      end
      if (accept && op == OP_CLEAR) begin
        count <= '0;
        bminx <= TOP; bminy <= TOP; bmaxx <= BOT; bmaxy <= BOT;
      end
    end
  end

  logic signed [PW-1:0] sx6, sy6, ey6;
  assign sx6 = PW'(sx) * PW'(6);
  assign sy6 = PW'(sy) * PW'(6);
  assign ey6 = PW'(ey) * PW'(6);

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (accept) begin
        cur_op <= op;
        inside_res <= 1'b0;
        point_x_six <= '0;
        point_y_six <= '0;
        if (op == OP_APPEND && count == CW'(MAX_VERTICES)) status <= ST_FULL;
        else if ((op == OP_CONTAINS || op == OP_INTERIOR) && count < CW'(3)) status <= ST_FEW;
        else status <= ST_OK;
        px <= PW'(x_coord) * PW'(6);
        py <= PW'(y_coord) * PW'(6);
        cand <= '0;
        cnum <= 2'd1;
        ei <= '0;
        wind <= '0;
        accx <= '0; accy <= '0;
      end
      S_CAND_RD: cnum <= 2'd2;
      S_CAND_A: begin
        accx <= PW'(rx); accy <= PW'(ry);
        cnum <= 2'd0;
      end
      S_CAND_B: begin
        accx <= accx + PW'(rx); accy <= accy + PW'(ry);
      end
      S_CAND_C: begin
        px <= (accx + PW'(rx)) <<< 1;
        py <= (accy + PW'(ry)) <<< 1;
        ei <= '0; wind <= '0;
      end
      S_EDGE_RD: begin
        // vertex 0, read in the cycle before, opens the walk
        if (ei == '0) begin
          sx <= rx; sy <= ry;
        end
      end
      S_EDGE_A: begin
        ex <= rx; ey <= ry;
      end
      S_EDGE_B: begin
        dx <= DW'(ex) - DW'(sx);
        dy <= DW'(ey) - DW'(sy);
        ox <= OW'(px) - OW'(sx6);
        oy <= OW'(py) - OW'(sy6);
      end
      S_EDGE_C: begin
        m1 <= MW'(dx) * MW'(oy);
        m2 <= MW'(dy) * MW'(ox);
      end
      S_EDGE_D: begin
        up <= (sy6 <= py) && (ey6 > py) && (m1 > m2);
        dn <= !(sy6 <= py) && (ey6 <= py) && (m1 < m2);
      end
      S_EDGE_E: begin
        sx <= ex; sy <= ey;
        if (!last_edge) begin
          wind <= wind_next;
          ei <= ei_next;
        end else if (cur_op == OP_CONTAINS) begin
          inside_res <= (wind_next != '0);
        end else if (wind_next != '0) begin
          inside_res <= 1'b1;
          point_x_six <= px;
          point_y_six <= py;
        end else begin
          cand <= cand + CW'(1);
          cnum <= 2'd1;
          ei <= '0; wind <= '0;
          if (cand + CW'(1) == count) begin
            px <= PW'(3) * (PW'(bminx) + PW'(bmaxx));
            py <= PW'(3) * (PW'(bminy) + PW'(bmaxy));
          end
        end
      end
      default: ;
    endcase
  end

  `PWC_ASSERT_IMP(a_busy_done, done, !busy)
  `PWC_ASSERT_NEXT(a_done_pulse, done, !done)
  `PWC_ASSERT_IMP(a_count_max, 1'b1, count <= CW'(MAX_VERTICES))
  `PWC_ASSERT_IMP(a_few, done && status == ST_FEW, !inside_res)
endmodule
